@@ rtl/bmpd_pkg.sv @@
// Shared types, constants and pixel scaling for the bitmap pixel decoder.
`default_nettype none

package bmpd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PixW   = 4;
  localparam int unsigned CountW = 16;
  localparam int unsigned LeftW  = 4;

  // 1/17 as 241/4096, exact after flooring for every 8-bit value
  localparam logic [7:0] Div17Recip = 8'd241;
  localparam logic [PixW-1:0] FullLevel = 4'hF;

  typedef enum logic [1:0] {
    DEPTH_1 = 2'd0,
    DEPTH_2 = 2'd1,
    DEPTH_4 = 2'd2,
    DEPTH_8 = 2'd3
  } depth_e;

  typedef enum logic [1:0] {
    REG_RLE_ENABLE = 2'd0,
    REG_DEPTH_CODE = 2'd1,
    REG_DATA_SIZE  = 2'd2
  } cfg_reg_e;

  // Byte handed from the counting stage to the unpacker
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             rle;
    depth_e           depth;
  } load_t;

  // Scale the field in the top bits of a shifted byte to 0..15
  function automatic logic [PixW-1:0] scale_field(logic [ByteW-1:0] top, depth_e depth);
    logic [15:0] prod;
    logic [PixW-1:0] res;
    prod = {8'd0, top} * {8'd0, Div17Recip};
    unique case (depth)
      DEPTH_1: res = top[7] ? FullLevel : '0;
      DEPTH_2: res = {top[7:6], 2'b00} + {2'b00, top[7:6]};
      DEPTH_4: res = top[7:4];
      DEPTH_8: res = prod[15:12];
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bmpd_gate.sv @@
// Configuration registers, byte counter and data-size gate.
`default_nettype none

module bmpd_gate (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  input  wire logic [1:0]                    cfg_index_i,
  input  wire logic [15:0]                   cfg_data_i,
  input  wire logic                          accept_i,
  input  wire logic [bmpd_pkg::ByteW-1:0]    data_byte_i,
  input  wire logic                          first_byte_i,
  output bmpd_pkg::load_t                    load_o
);

  logic                          rle_q, rle_d;
  bmpd_pkg::depth_e              depth_q, depth_d;
  logic [bmpd_pkg::CountW-1:0]   size_q, size_d;
  logic [bmpd_pkg::CountW-1:0]   cnt_q, cnt_d;
  logic [bmpd_pkg::CountW-1:0]   cnt_eff;
  logic                          keep;

  always_comb begin
    rle_d   = rle_q;
    depth_d = depth_q;
    size_d  = size_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        bmpd_pkg::REG_RLE_ENABLE: rle_d   = cfg_data_i[0];
        bmpd_pkg::REG_DEPTH_CODE: depth_d = bmpd_pkg::depth_e'(cfg_data_i[1:0]);
        bmpd_pkg::REG_DATA_SIZE:  size_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  // A marked first byte clears the count even when it is dropped
  assign cnt_eff = first_byte_i ? '0 : cnt_q;
  assign keep    = cnt_eff < size_q;

  always_comb begin
    cnt_d = cnt_q;
    if (accept_i) begin
      cnt_d = keep ? cnt_eff + 16'd1 : cnt_eff;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rle_q   <= 1'b0;
      depth_q <= bmpd_pkg::DEPTH_4;
      size_q  <= '0;
      cnt_q   <= '0;
    end else begin
      rle_q   <= rle_d;
      depth_q <= depth_d;
      size_q  <= size_d;
      cnt_q   <= cnt_d;
    end
  end

  assign load_o.valid = accept_i && keep;
  assign load_o.data  = data_byte_i;
  assign load_o.rle   = rle_q;
  assign load_o.depth = depth_q;

endmodule

`default_nettype wire

@@ rtl/bmpd_unpack.sv @@
// Shift-register unpacker: one pixel per cycle into an output register, unless the output stalls.
`default_nettype none

module bmpd_unpack (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire bmpd_pkg::load_t             load_i,
  output logic                             busy_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [bmpd_pkg::PixW-1:0]        out_pixel_o,
  output logic                             out_last_o
);

  logic                          busy_q, busy_d;
  logic [bmpd_pkg::ByteW-1:0]    shreg_q, shreg_d;
  logic [bmpd_pkg::LeftW-1:0]    left_q, left_d;
  logic                          rle_q, rle_d;
  bmpd_pkg::depth_e              depth_q, depth_d;
  logic                          ovalid_q, ovalid_d;
  logic [bmpd_pkg::PixW-1:0]     opix_q, opix_d;
  logic                          olast_q, olast_d;
  logic                          emit;
  logic [bmpd_pkg::PixW-1:0]     pix;
  logic [bmpd_pkg::ByteW-1:0]    shifted;
  logic [bmpd_pkg::LeftW-1:0]    left_init;

  assign emit = busy_q && (!ovalid_q || out_ready_i);

  assign pix = rle_q ? shreg_q[3:0] : bmpd_pkg::scale_field(shreg_q, depth_q);

  always_comb begin
    unique case (depth_q)
      bmpd_pkg::DEPTH_1: shifted = {shreg_q[6:0], 1'b0};
      bmpd_pkg::DEPTH_2: shifted = {shreg_q[5:0], 2'b00};
      bmpd_pkg::DEPTH_4: shifted = {shreg_q[3:0], 4'h0};
      bmpd_pkg::DEPTH_8: shifted = '0;
      default:           shifted = '0;
    endcase
  end

  // Pixels in the byte, minus one
  always_comb begin
    if (load_i.rle) begin
      left_init = load_i.data[7:4];
    end else begin
      unique case (load_i.depth)
        bmpd_pkg::DEPTH_1: left_init = 4'd7;
        bmpd_pkg::DEPTH_2: left_init = 4'd3;
        bmpd_pkg::DEPTH_4: left_init = 4'd1;
        bmpd_pkg::DEPTH_8: left_init = 4'd0;
        default:           left_init = 4'd0;
      endcase
    end
  end

  always_comb begin
    busy_d  = busy_q;
    shreg_d = shreg_q;
    left_d  = left_q;
    rle_d   = rle_q;
    depth_d = depth_q;
    if (load_i.valid) begin
      busy_d  = 1'b1;
      shreg_d = load_i.data;
      left_d  = left_init;
      rle_d   = load_i.rle;
      depth_d = load_i.depth;
    end else if (emit) begin
      // RLE keeps its level in place; packed mode advances to the next field
      if (!rle_q) begin
        shreg_d = shifted;
      end
      left_d = left_q - 4'd1;
      if (left_q == '0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    ovalid_d = ovalid_q;
    opix_d   = opix_q;
    olast_d  = olast_q;
    if (emit) begin
      ovalid_d = 1'b1;
      opix_d   = pix;
      olast_d  = (left_q == '0);
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    left_q  <= left_d;
    rle_q   <= rle_d;
    depth_q <= depth_d;
    opix_q  <= opix_d;
    olast_q <= olast_d;
  end

  assign busy_o      = busy_q;
  assign out_valid_o = ovalid_q;
  assign out_pixel_o = opix_q;
  assign out_last_o  = olast_q;

  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i.valid |-> !busy_q)
    else $error("byte loaded while unpacker busy");

  a_emit_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> ovalid_q)
    else $error("emitted pixel not held in output register");

  a_final_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && left_q == '0) |=> (!busy_q && olast_q))
    else $error("final pixel did not end the byte");

  a_packed_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !rle_q) |-> (left_q <= 4'd7))
    else $error("packed pixel count out of range");

endmodule

`default_nettype wire

@@ rtl/bitmap_rle_or_packed_pixel_decoder.sv @@
// Top level of the run-length / packed bitmap pixel decoder.
//
// Usage:
//   Bytes of image data enter on the s_axis channel; tdata carries the byte
//   and tuser flags the first byte of an image, which clears the byte count.
//   Grey pixels (4 bits, in tdata[3:0]) leave on the m_axis channel; tlast
//   marks the final pixel decoded from a byte.
//   Registers are written through the cfg channel (always ready): index 0
//   rle_enable, 1 depth_code, 2 data_size; index 3 is ignored. Write them
//   only while the block is idle.
// Timing:
//   A byte yields N pixels (RLE: high nibble + 1, 1..16; packed: 8, 4, 2
//   or 1 for 1/2/4/8 bpp) and occupies the unpacker: it loads its shift
//   register, then one pixel per cycle while the output is not stalled.
//   The first pixel is valid after the shift register and the output
//   register. A byte beyond data_size is dropped in its accept cycle and gives no pixels.
//   The output register parts the channels: the next byte is taken as soon
//   as the last pixel of the current one has moved into it.
// Reset: clears the counter, the registers (depth 4 bpp, size 0, packed mode)
//   and all valid state. A stalled receiver freezes the unpacker and holds
//   the pending pixel; s_axis_tready stays low until the byte is unpacked.
`default_nettype none

module bitmap_rle_or_packed_pixel_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input word
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  wire logic        s_axis_tuser_i,   // [0] first_byte
  // output word
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,   // [3:0] pixel, [7:4] zero
  output logic             m_axis_tlast_o,   // last_of_byte
  // register writes
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);

  bmpd_pkg::load_t               load;
  logic                          busy;
  logic                          accept;
  logic [bmpd_pkg::PixW-1:0]     pixel;

  // Accept a new byte only when the unpacker has finished the last one
  assign s_axis_tready_o = !busy;
  assign accept          = s_axis_tvalid_i && !busy;
  assign cfg_ready_o     = 1'b1;

  bmpd_gate u_gate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .accept_i     (accept),
    .data_byte_i  (s_axis_tdata_i),
    .first_byte_i (s_axis_tuser_i),
    .load_o       (load)
  );

  bmpd_unpack u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .busy_o      (busy),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_pixel_o (pixel),
    .out_last_o  (m_axis_tlast_o)
  );

  // Pad the pixel to a whole byte
  assign m_axis_tdata_o = {4'h0, pixel};

endmodule

`default_nettype wire

@@ tb/sv/tb_bitmap_rle_or_packed_pixel_decoder.sv @@
// Self-checking testbench for the run-length / packed bitmap pixel decoder.
`timescale 1ns / 100ps
`default_nettype none

module tb_bitmap_rle_or_packed_pixel_decoder;

  // Index past the last register: writes to it must be ignored
  localparam logic [1:0] RegUnused = 2'd3;
  // Cycles to let pass after the last pixel before touching the registers
  localparam int unsigned SettleCycles = 4;
  // Random bytes to send, dropped ones included
  localparam int unsigned RandomBytes = 380;

  typedef struct packed {
    logic [bmpd_pkg::PixW-1:0] pixel;
    logic                      last;
  } pix_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tuser;   // [0] first_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [3:0] pixel, [7:4] zero
  logic        m_axis_tlast;   // last_of_byte
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  bitmap_rle_or_packed_pixel_decoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tlast_o  (m_axis_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // Shadow copy of the block's registers and byte counter
  logic              shadow_rle;
  bmpd_pkg::depth_e  shadow_depth;
  logic [15:0]       shadow_size;
  logic [15:0]       bytes_taken;

  // Pixels predicted but not yet seen on the output, oldest first
  pix_t expected_pixels[$];
  pix_t want_pix;

  // Hold both sides busy-free while set
  logic no_idle;

  int unsigned error_count;
  int unsigned pixel_bytes;
  int unsigned dropped_bytes;
  int unsigned pixels_checked;
  int unsigned settings_used;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Scale a field to 0..15 as v*15/mask, rounded down
  function automatic logic [bmpd_pkg::PixW-1:0] grey_level(int unsigned v,
                                                           int unsigned mask);
    int unsigned q;
    q = (v * 15) / mask;
    return q[bmpd_pkg::PixW-1:0];
  endfunction

  // Advance the shadow counter for one accepted byte and queue its pixels.
  // Return how many pixels the byte gives (0 when it is dropped).
  function automatic int queue_pixels(logic [7:0] b, logic first);
    pix_t        p;
    int unsigned bpp;
    int unsigned mask;
    int unsigned left;
    int unsigned run;
    int          n;
    n = 0;
    if (first) bytes_taken = '0;
    // Drop any byte beyond the configured size, counter holds
    if (bytes_taken >= shadow_size) return 0;
    bytes_taken++;
    if (shadow_rle) begin
      run = int'(b[7:4]) + 1;
      for (int unsigned k = 0; k < run; k++) begin
        p.pixel = b[3:0];
        p.last  = (k + 1 == run);
        expected_pixels.push_back(p);
        n++;
      end
    end else begin
      bpp  = 1 << shadow_depth;
      mask = (1 << bpp) - 1;
      left = 8;
      // Cut the byte MSB-first
      while (left != 0) begin
        left -= bpp;
        p.pixel = grey_level((int'(b) >> left) & mask, mask);
        p.last  = (left == 0);
        expected_pixels.push_back(p);
        n++;
      end
    end
    return n;
  endfunction

  // Send one byte; called and returning at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic first);
    if (!no_idle) begin
      while ($urandom_range(0, 99) < 9) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tuser  = first;
    do @(posedge clk_i); while (!s_axis_tready);
    if (queue_pixels(b, first) > 0) pixel_bytes++;
    else dropped_bytes++;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
  endtask

  // Write one register; called and returning at a falling edge
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      bmpd_pkg::REG_RLE_ENABLE: shadow_rle   = val[0];
      bmpd_pkg::REG_DEPTH_CODE: shadow_depth = bmpd_pkg::depth_e'(val[1:0]);
      bmpd_pkg::REG_DATA_SIZE:  shadow_size  = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input logic rle, input bmpd_pkg::depth_e depth,
                           input logic [15:0] size);
    write_reg(bmpd_pkg::REG_RLE_ENABLE, {15'd0, rle});
    write_reg(bmpd_pkg::REG_DEPTH_CODE, {14'd0, depth});
    write_reg(bmpd_pkg::REG_DATA_SIZE, size);
    settings_used++;
  endtask

  // Hold until every predicted pixel has left, then let the block settle
  task automatic wait_drained();
    while (expected_pixels.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Receiver: stall at random, with a chance of 9 in 100
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready = no_idle || ($urandom_range(0, 99) >= 9);
  end

  // Compare each accepted pixel word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel word 0x%02h with none expected", m_axis_tdata));
      end else begin
        want_pix = expected_pixels.pop_front();
        pixels_checked++;
        if (m_axis_tdata !== {4'd0, want_pix.pixel})
          report_mismatch($sformatf("tdata 0x%02h, want 0x%02h",
                                    m_axis_tdata, {4'd0, want_pix.pixel}));
        if (m_axis_tlast !== want_pix.last)
          report_mismatch($sformatf("tlast %b, want %b", m_axis_tlast, want_pix.last));
      end
    end
  end

  // Reset values: size 0 drops everything, then packed 4 bpp by default
  task automatic test_reset_defaults();
    send_byte(8'hA5, 1'b1);
    send_byte(8'h3C, 1'b0);
    wait_drained();
    write_reg(bmpd_pkg::REG_DATA_SIZE, 16'd8);
    send_byte(8'h9E, 1'b1);
    wait_drained();
  endtask

  // Every depth with the extreme field values
  task automatic test_packed_depths();
    configure(1'b0, bmpd_pkg::DEPTH_1, 16'd16);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    wait_drained();
    configure(1'b0, bmpd_pkg::DEPTH_2, 16'd16);
    send_byte(8'h1B, 1'b1);
    wait_drained();
    configure(1'b0, bmpd_pkg::DEPTH_4, 16'd16);
    send_byte(8'h0F, 1'b1);
    wait_drained();
    configure(1'b0, bmpd_pkg::DEPTH_8, 16'd16);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hEF, 1'b0);
    send_byte(8'h00, 1'b0);
    wait_drained();
  endtask

  // Shortest and longest runs, black and full levels
  task automatic test_rle_runs();
    configure(1'b1, bmpd_pkg::DEPTH_4, 16'd16);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h7A, 1'b0);
    wait_drained();
  endtask

  // Bytes past the size are dropped until a first byte restarts the count
  task automatic test_size_limit();
    configure(1'b0, bmpd_pkg::DEPTH_2, 16'd2);
    send_byte(8'h6C, 1'b1);
    send_byte(8'h93, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h27, 1'b1);
    wait_drained();
    configure(1'b1, bmpd_pkg::DEPTH_2, 16'hFFFF);
    send_byte(8'h35, 1'b1);
    wait_drained();
  endtask

  // Wide values keep only their low bits; the unused index changes nothing
  task automatic test_register_masking();
    write_reg(bmpd_pkg::REG_RLE_ENABLE, 16'hFFFE);
    write_reg(bmpd_pkg::REG_DEPTH_CODE, 16'hFFFD);
    write_reg(RegUnused, 16'h0001);
    settings_used++;
    send_byte(8'hD2, 1'b1);
    send_byte(8'h4B, 1'b0);
    wait_drained();
  endtask

  // Random images under changing settings
  task automatic test_random_images();
    int unsigned target;
    int unsigned phase;
    int unsigned attempts;
    int unsigned len;
    logic [15:0] size;
    logic        first;
    target = pixel_bytes + dropped_bytes + RandomBytes;
    phase  = 0;
    while (pixel_bytes + dropped_bytes < target) begin
      case (phase % 8)
        0:       size = 16'hFFFF;
        1:       size = 16'd1;
        2:       size = 16'd0;
        default: size = 16'($urandom_range(2, 40));
      endcase
      configure(1'($urandom_range(0, 1)), bmpd_pkg::depth_e'($urandom_range(0, 3)), size);
      // One long stretch with no idling on either side
      no_idle  = (phase == 4);
      attempts = (size == 0) ? 8 : $urandom_range(30, 60);
      for (int unsigned a = 0; a < attempts; ) begin
        len = $urandom_range(1, 20);
        for (int unsigned i = 0; i < len && a < attempts; i++, a++) begin
          first = (i == 0);
          // Noise: a stray or missing first-byte flag
          if ($urandom_range(0, 99) < 10) first = 1'($urandom_range(0, 1));
          send_byte(8'($urandom_range(0, 255)), first);
          // Hold off the sender once until the output side has caught up
          if (phase == 3 && a == attempts / 2) wait_drained();
        end
      end
      wait_drained();
      no_idle = 1'b0;
      phase++;
    end
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = 1'b0;
    m_axis_tready  = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    no_idle        = 1'b0;
    shadow_rle     = 1'b0;
    shadow_depth   = bmpd_pkg::DEPTH_4;
    shadow_size    = '0;
    bytes_taken    = '0;
    error_count    = 0;
    pixel_bytes    = 0;
    dropped_bytes  = 0;
    pixels_checked = 0;
    settings_used  = 1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_packed_depths();
    test_rle_runs();
    test_size_limit();
    test_register_masking();
    test_random_images();

    // Catch any stray pixel after the last one expected
    wait_drained();
    repeat (40) @(negedge clk_i);

    $display("Covered %0d pixel bytes and %0d dropped bytes over %0d register settings,",
             pixel_bytes, dropped_bytes, settings_used);
    $display("both decode modes and all depths; %0d pixel words checked.", pixels_checked);
    if (error_count == 0) begin
      $display("bitmap_rle_or_packed_pixel_decoder test passed");
    end else begin
      $display("bitmap_rle_or_packed_pixel_decoder test failed");
    end
    $finish;
  end

  // Watchdog: end a hung run
  initial begin
    #2_000_000;
    $display("Timeout with %0d pixels still expected", expected_pixels.size());
    $display("bitmap_rle_or_packed_pixel_decoder test failed");
    $finish;
  end

endmodule

`default_nettype wire
